// File: rtl/core/static_kalman_position_filter_core_macros.svh
// Assertion helpers for the position filter core.
`ifndef STATIC_KALMAN_POSITION_FILTER_CORE_MACROS_SVH
`define STATIC_KALMAN_POSITION_FILTER_CORE_MACROS_SVH

`ifndef SYNTH
`define SKPF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("skpf assertion failed");
`define SKPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("skpf assertion failed");
`else
`define SKPF_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SKPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/skpf_pkg.sv
package skpf_pkg;

  localparam int AXES      = 3;
  localparam int FRAC_BITS = 30;
  localparam int GAIN_W    = 31;
  localparam int PP_W      = 33;
  localparam int DEN_W     = 34;
  localparam int POS_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE  = 2'd2;

  localparam logic [29:0] PROCESS_NOISE_RST     = 30'd107374;
  localparam logic [29:0] MEASUREMENT_NOISE_RST = 30'd536871;
  localparam logic [31:0] INITIAL_VARIANCE_RST  = 32'd1073741824;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul;
    logic upd;
  } lane_ctrl_t;

  typedef logic [AXES-1:0][POS_W-1:0] pos_vec_t;

endpackage

// File: rtl/core/skpf_gain_div.sv
module skpf_gain_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [skpf_pkg::PP_W-1:0]       pp,
  input  logic [skpf_pkg::DEN_W-1:0]      den,
  output logic                            done,
  output logic [skpf_pkg::GAIN_W-1:0]     gain
);

  localparam int CNT_W = $clog2(skpf_pkg::GAIN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(skpf_pkg::GAIN_W - 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [skpf_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [skpf_pkg::DEN_W-1:0]    den_r, den_nxt;
  logic [skpf_pkg::GAIN_W-1:0]   q_r, q_nxt;
  logic                          nbit_r, nbit_nxt;
  logic                          zero_r, zero_nxt;
  logic [skpf_pkg::DEN_W:0]      trial;
  logic [skpf_pkg::DEN_W:0]      diff;
  logic                          take;

  // restoring division of pp * 2^30 by den; quotient never exceeds 31 bits
  assign trial = {rem_r, nbit_r};
  assign diff  = trial - {1'b0, den_r};
  assign take  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    nbit_nxt = nbit_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {2'b00, pp[skpf_pkg::PP_W-1:1]};
      nbit_nxt = pp[0];
      den_nxt  = den;
      zero_nxt = (den == '0);
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = take ? diff[skpf_pkg::DEN_W-1:0] : trial[skpf_pkg::DEN_W-1:0];
      q_nxt    = {q_r[skpf_pkg::GAIN_W-2:0], take};
      nbit_nxt = 1'b0;
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    nbit_r <= nbit_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign gain = zero_r ? '0 : q_r;

endmodule

// File: rtl/core/skpf_lane.sv
module skpf_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  skpf_pkg::lane_ctrl_t               ctrl,
  input  logic signed [skpf_pkg::POS_W-1:0]  meas,
  input  logic [skpf_pkg::GAIN_W-1:0]        gain,
  output logic [skpf_pkg::POS_W-1:0]         est
);

  logic signed [skpf_pkg::POS_W-1:0]  meas_r, meas_nxt;
  logic signed [skpf_pkg::POS_W-1:0]  est_r, est_nxt;
  logic signed [63:0]                 prod_r, prod_nxt;
  logic signed [skpf_pkg::POS_W:0]    diff;
  logic signed [64:0]                 prod_full;
  logic signed [63:0]                 step;

  assign diff      = {meas_r[skpf_pkg::POS_W-1], meas_r} - {est_r[skpf_pkg::POS_W-1], est_r};
  assign prod_full = $signed({1'b0, gain}) * diff;
  assign step      = prod_r >>> skpf_pkg::FRAC_BITS;

  always_comb begin
    meas_nxt = ctrl.capture ? meas : meas_r;
    prod_nxt = ctrl.mul ? prod_full[63:0] : prod_r;
    est_nxt  = est_r;
    if (ctrl.load) begin
      est_nxt = meas;
    end else if (ctrl.upd) begin
      est_nxt = est_r + step[skpf_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
    end else begin
      est_r <= est_nxt;
    end
    meas_r <= meas_nxt;
    prod_r <= prod_nxt;
  end

  assign est = est_r;

endmodule

// File: rtl/core/skpf_merge.sv
module skpf_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  skpf_pkg::pos_vec_t       lane_est,
  input  logic                     first,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [31:0]       out_est_x,
  output logic signed [31:0]       out_est_y,
  output logic signed [31:0]       out_est_z,
  output logic                     out_first_sample
);

  logic                 valid_r, valid_nxt;
  skpf_pkg::pos_vec_t   est_r, est_nxt;
  logic                 first_r, first_nxt;

  always_comb begin
    valid_nxt = valid_r;
    est_nxt   = est_r;
    first_nxt = first_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      est_nxt   = lane_est;
      first_nxt = first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    est_r   <= est_nxt;
    first_r <= first_nxt;
  end

  assign out_valid        = valid_r;
  assign out_est_x        = est_r[0];
  assign out_est_y        = est_r[1];
  assign out_est_z        = est_r[2];
  assign out_first_sample = first_r;

endmodule

// File: rtl/core/static_kalman_position_filter_core.sv
// Constant-position Kalman filter for 3-D points, signed Q16.16.
// Input channel: in_valid/in_stall with in_meas_x/y/z; a transaction is taken
// when in_valid is high and in_stall low. Result channel: out_valid/out_stall
// with out_est_x/y/z and out_first_sample, one result per input transaction.
// Config port: cfg_we, cfg_index, cfg_data; write only while the core is idle.
// Index 0 process noise, 1 measurement noise, 2 initial variance (UQ2.30).
// Flow: the first transaction after reset is copied straight to the result
// register. Later ones pass through acceptance, the bit-serial gain divider,
// a register that hands over the gain, the multiply and update steps shared
// by the three axis lanes, then the result register. One transaction is in
// work at a time, so a new one is not accepted until the previous one has
// been loaded into the result register.
// A new transaction may be accepted while the previous result is still held.
// When the receiver stalls, the result is held stable in the output register;
// a finished transaction waits in its last state until the register frees up.
// Reset (synchronous, rst_n low) restores register defaults, clears the
// estimate and the started flag, and loads the variance with 1.0.
module static_kalman_position_filter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_meas_x,
  input  logic signed [31:0]  in_meas_y,
  input  logic signed [31:0]  in_meas_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_est_x,
  output logic signed [31:0]  out_est_y,
  output logic signed [31:0]  out_est_z,
  output logic                out_first_sample,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  `include "static_kalman_position_filter_core_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                               state_r, state_nxt;
  logic [29:0]                          q_r, q_nxt;
  logic [29:0]                          r_r, r_nxt;
  logic [31:0]                          init_var_r, init_var_nxt;
  logic [31:0]                          var_r, var_nxt;
  logic                                 started_r, started_nxt;
  logic                                 first_r, first_nxt;
  logic [skpf_pkg::PP_W-1:0]            pp_r, pp_nxt;
  logic [63:0]                          vprod_r, vprod_nxt;
  logic [skpf_pkg::PP_W-1:0]            pp_new;
  logic [skpf_pkg::DEN_W-1:0]           den_new;
  logic [skpf_pkg::GAIN_W-1:0]          one_minus_gain;
  logic [33:0]                          var_q;
  logic [31:0]                          var_sat;
  logic                                 accept;
  logic                                 div_start;
  logic                                 div_done;
  logic [skpf_pkg::GAIN_W-1:0]          gain;
  logic                                 merge_load;
  skpf_pkg::lane_ctrl_t                 lane_ctrl;
  skpf_pkg::pos_vec_t                   meas_vec;
  skpf_pkg::pos_vec_t                   est_vec;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign pp_new  = {1'b0, var_r} + {3'b000, q_r};
  assign den_new = {1'b0, pp_new} + {4'b0000, r_r};

  assign one_minus_gain = skpf_pkg::GAIN_ONE - gain;
  assign var_q          = vprod_r[63:skpf_pkg::FRAC_BITS];
  assign var_sat        = (var_q[33:32] != 2'b00) ? 32'hFFFF_FFFF : var_q[31:0];

  assign div_start  = accept && started_r;
  assign merge_load = (state_r == S_OUT) && (!out_valid || !out_stall);

  assign lane_ctrl.capture = accept;
  assign lane_ctrl.load    = accept && !started_r;
  assign lane_ctrl.mul     = (state_r == S_MUL);
  assign lane_ctrl.upd     = (state_r == S_UPD);

  assign meas_vec[0] = in_meas_x;
  assign meas_vec[1] = in_meas_y;
  assign meas_vec[2] = in_meas_z;

  always_comb begin
    state_nxt    = state_r;
    q_nxt        = q_r;
    r_nxt        = r_r;
    init_var_nxt = init_var_r;
    var_nxt      = var_r;
    started_nxt  = started_r;
    first_nxt    = first_r;
    pp_nxt       = pp_r;
    vprod_nxt    = vprod_r;

    if (cfg_we) begin
      case (cfg_index)
        skpf_pkg::CFG_PROCESS_NOISE:     q_nxt = cfg_data[29:0];
        skpf_pkg::CFG_MEASUREMENT_NOISE: r_nxt = cfg_data[29:0];
        skpf_pkg::CFG_INITIAL_VARIANCE: begin
          init_var_nxt = cfg_data;
          if (!started_r) begin
            var_nxt = cfg_data;
          end
        end
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          first_nxt = !started_r;
          pp_nxt    = pp_new;
          if (started_r) begin
            state_nxt = S_DIV;
          end else begin
            started_nxt = 1'b1;
            state_nxt   = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        vprod_nxt = {33'd0, one_minus_gain} * {31'd0, pp_r};
        state_nxt = S_UPD;
      end
      S_UPD: begin
        var_nxt   = var_sat;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (merge_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      q_r        <= skpf_pkg::PROCESS_NOISE_RST;
      r_r        <= skpf_pkg::MEASUREMENT_NOISE_RST;
      init_var_r <= skpf_pkg::INITIAL_VARIANCE_RST;
      var_r      <= skpf_pkg::INITIAL_VARIANCE_RST;
      started_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      q_r        <= q_nxt;
      r_r        <= r_nxt;
      init_var_r <= init_var_nxt;
      var_r      <= var_nxt;
      started_r  <= started_nxt;
    end
    first_r <= first_nxt;
    pp_r    <= pp_nxt;
    vprod_r <= vprod_nxt;
  end

  skpf_gain_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .pp    (pp_new),
    .den   (den_new),
    .done  (div_done),
    .gain  (gain)
  );

  for (genvar a = 0; a < skpf_pkg::AXES; a++) begin : g_lane
    skpf_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .meas  (meas_vec[a]),
      .gain  (gain),
      .est   (est_vec[a])
    );
  end

  skpf_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (merge_load),
    .lane_est         (est_vec),
    .first            (first_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_est_x        (out_est_x),
    .out_est_y        (out_est_y),
    .out_est_z        (out_est_z),
    .out_first_sample (out_first_sample)
  );

  `SKPF_ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_done, state_r == S_DIV)
  `SKPF_ASSERT_SAME(a_gain_max, clk, rst_n, div_done, gain <= skpf_pkg::GAIN_ONE)
  `SKPF_ASSERT_NEXT(a_started_sticks, clk, rst_n, started_r, started_r)
  `SKPF_ASSERT_NEXT(a_first_on_load, clk, rst_n, merge_load, out_first_sample == first_r)

endmodule
